// ===== src/ppmd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmd_pkg
// Types, codes and constants shared by the pulse train decoder, its shared
// subtractor and its port checker.
// ----------------------------------------------------------------------------
package ppmd_pkg;

    // Default channel limit of a frame.
    localparam int MAX_CHAN_DEF = 6;

    // Input event codes.
    localparam logic [1:0] REQ_PULSE   = 2'd0;
    localparam logic [1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    // Link modes as they appear on the output.
    localparam logic [1:0] MODE_WAIT = 2'd0;
    localparam logic [1:0] MODE_OK   = 2'd1;
    localparam logic [1:0] MODE_FS   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_NEEDED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_THROTTLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_NEUTRAL    = 3'd5;

    // Register reset values.
    localparam logic [15:0] RST_PULSE_MIN     = 16'd750;
    localparam logic [15:0] RST_PULSE_MAX     = 16'd2250;
    localparam logic [15:0] RST_SYNC_MIN      = 16'd5000;
    localparam logic [7:0]  RST_FRAMES_NEEDED = 8'd2;
    localparam logic [15:0] RST_FS_THROTTLE   = 16'd1000;
    localparam logic [15:0] RST_FS_NEUTRAL    = 16'd1500;

    // Frame encoding constants.
    localparam logic [15:0] PULSE_OFFSET = 16'd1000;
    localparam logic [7:0]  BIND_FLAG    = 8'h80;
    localparam logic [7:0]  GOOD_MAX     = 8'hff;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] pulse_ticks;
        logic        bind_req;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       from_failsafe;
        logic [1:0] link_state;
    } t_out_item;

endpackage

// ===== src/ppmd_sub.sv =====
// ----------------------------------------------------------------------------
// ppmd_sub
// Shared 16-bit subtractor with borrow out. It serves the pulse class
// compares and the offset removal of every channel value.
// ----------------------------------------------------------------------------
module ppmd_sub
    import ppmd_pkg::*;
(
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [15:0] o_diff,
    output logic        o_borrow
);

    logic [16:0] w_full;

    // The top bit is set when i_b is greater than i_a.
    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[15:0];
    assign o_borrow = w_full[16];

endmodule

// ===== src/ppm_decode_to_serial_frame_top.sv =====
// ----------------------------------------------------------------------------
// ppm_decode_to_serial_frame_top
// PPM pulse train decoder that emits serial frames, one byte per beat.
// ----------------------------------------------------------------------------
// A captured pulse is taken in the idle state, then one subtractor performs
// the compares against pulse_min, pulse_max and sync_min in turn, and the sync
// compare state also updates the frame counters. A timeout is handled in the
// idle state, and so is a tick that sends nothing. When a frame is due, the
// block then sends 2 + 2 * channels bytes at up to one byte per cycle while
// the output is not stalled. The input is not ready until the last byte of a
// frame has been placed in the output register.
// ----------------------------------------------------------------------------
module ppm_decode_to_serial_frame_top
    import ppmd_pkg::*;
#(
    parameter int MAX_CHAN = MAX_CHAN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_CHAN + 2);
    localparam int IDX_W = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CHAN);
    localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_CHAN + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CMP_MIN  = 8'b0000_0010,
        S_CMP_MAX  = 8'b0000_0100,
        S_CMP_SYNC = 8'b0000_1000,
        S_HDR0     = 8'b0001_0000,
        S_HDR1     = 8'b0010_0000,
        S_CH_HI    = 8'b0100_0000,
        S_CH_LO    = 8'b1000_0000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [15:0] r_pulse_min, r_pulse_max, r_sync_min;
    logic [7:0]  r_frames_needed;
    logic [15:0] r_fs_throttle, r_fs_neutral;

    // Link tracking state.
    logic [1:0]       r_mode;
    logic [7:0]       r_good;
    logic [CNT_W-1:0] r_seen;
    logic [CNT_W-1:0] r_last;
    logic [CNT_W-1:0] r_found;
    logic             r_bind;
    logic [15:0]      r_store [MAX_CHAN];

    // Working registers of one event.
    logic [15:0]      r_len;
    logic             r_ge_min;
    logic             r_le_max;
    logic             r_fs;
    logic [CNT_W-1:0] r_ch;
    logic [7:0]       r_lo_byte;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    // Shared subtractor.
    logic [15:0] w_a, w_b, w_diff;
    logic        w_borrow;
    logic [15:0] w_pval;

    ppmd_sub u_sub (
        .i_a     (w_a),
        .i_b     (w_b),
        .o_diff  (w_diff),
        .o_borrow(w_borrow)
    );

    always_comb begin
        if (r_fs) begin
            w_pval = (r_ch == '0) ? r_fs_throttle : r_fs_neutral;
        end else begin
            w_pval = r_store[r_ch[IDX_W-1:0]];
        end
    end

    always_comb begin
        case (r_state)
            S_CMP_MIN: begin
                w_a = r_len;
                w_b = r_pulse_min;
            end
            S_CMP_MAX: begin
                w_a = r_pulse_max;
                w_b = r_len;
            end
            S_CMP_SYNC: begin
                w_a = r_len;
                w_b = r_sync_min;
            end
            S_CH_HI: begin
                w_a = w_pval;
                w_b = PULSE_OFFSET;
            end
            default: begin
                w_a = r_len;
                w_b = r_pulse_min;
            end
        endcase
    end

    // Pulse classification and counter update, taken in the sync compare cycle.
    logic [CNT_W-1:0] n_seen, n_last, n_found;
    logic [7:0]       n_good;
    logic [1:0]       n_mode;
    logic             n_emit;
    logic             w_chan_pulse;

    assign w_chan_pulse = r_ge_min && r_le_max;

    always_comb begin
        logic good;
        good    = 1'b0;
        n_seen  = r_seen;
        n_good  = r_good;
        n_last  = r_last;
        n_found = r_found;
        n_mode  = r_mode;
        n_emit  = 1'b0;
        if (w_chan_pulse) begin
            if (r_seen < CNT_SAT) begin
                n_seen = r_seen + 1'b1;
            end
        end else if (!w_borrow) begin
            if (r_seen == r_last) begin
                if (r_good != GOOD_MAX) begin
                    n_good = r_good + 1'b1;
                end
                good = 1'b1;
            end else begin
                n_good = '0;
                n_last = (r_seen <= CNT_MAX) ? r_seen : '0;
            end
            n_seen = '0;
        end else begin
            n_good = '0;
            n_last = '0;
            n_seen = '0;
        end

        if (r_found == '0) begin
            if (n_good >= r_frames_needed) begin
                n_found = n_last;
                n_mode  = MODE_FS;
            end
        end else if (n_last != r_found) begin
            n_mode = MODE_FS;
        end else if (good) begin
            n_mode = MODE_OK;
            n_emit = 1'b1;
        end
    end

    // Byte that the current emit state offers.
    logic      w_load;
    logic      w_emitting;
    t_out_item n_out;

    assign w_emitting = (r_state == S_HDR0) || (r_state == S_HDR1) ||
                        (r_state == S_CH_HI) || (r_state == S_CH_LO);
    assign w_load     = w_emitting && (!r_out_valid || i_out_ready);

    always_comb begin
        n_out.from_failsafe = r_fs;
        n_out.link_state    = r_mode;
        n_out.last_byte     = 1'b0;
        case (r_state)
            S_HDR0: begin
                n_out.frame_byte = r_bind ? BIND_FLAG : 8'h00;
            end
            S_HDR1: begin
                n_out.frame_byte = 8'h00;
                n_out.last_byte  = (r_found == '0);
            end
            S_CH_HI: begin
                n_out.frame_byte = 8'(8'(r_ch) << 2) | {6'd0, w_diff[9:8]};
            end
            S_CH_LO: begin
                n_out.frame_byte = r_lo_byte;
                n_out.last_byte  = ((r_ch + 1'b1) == r_found);
            end
            default: begin
                n_out.frame_byte = 8'h00;
            end
        endcase
    end

    // Sequencer and link state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_WAIT;
            r_good  <= '0;
            r_seen  <= '0;
            r_last  <= '0;
            r_found <= '0;
            r_bind  <= 1'b0;
            r_fs    <= 1'b0;
            r_ch    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_in_data.req_type)
                            REQ_PULSE: begin
                                r_state <= S_CMP_MIN;
                            end
                            REQ_TIMEOUT: begin
                                if (r_mode != MODE_WAIT) begin
                                    r_mode <= MODE_FS;
                                    r_good <= '0;
                                    r_seen <= '0;
                                end
                            end
                            REQ_TICK: begin
                                r_bind <= i_in_data.bind_req;
                                if (r_mode == MODE_FS && r_found != '0) begin
                                    r_fs    <= 1'b1;
                                    r_state <= S_HDR0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CMP_MIN: begin
                    r_state <= S_CMP_MAX;
                end
                S_CMP_MAX: begin
                    r_state <= S_CMP_SYNC;
                end
                S_CMP_SYNC: begin
                    r_seen  <= n_seen;
                    r_good  <= n_good;
                    r_last  <= n_last;
                    r_found <= n_found;
                    r_mode  <= n_mode;
                    r_fs    <= 1'b0;
                    r_state <= n_emit ? S_HDR0 : S_IDLE;
                end
                S_HDR0: begin
                    if (w_load) begin
                        r_state <= S_HDR1;
                    end
                end
                S_HDR1: begin
                    if (w_load) begin
                        r_ch    <= '0;
                        r_state <= (r_found == '0) ? S_IDLE : S_CH_HI;
                    end
                end
                S_CH_HI: begin
                    if (w_load) begin
                        r_state <= S_CH_LO;
                    end
                end
                S_CH_LO: begin
                    if (w_load) begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= ((r_ch + 1'b1) == r_found) ? S_IDLE : S_CH_HI;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Event payload, compare results and pulse store.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_len <= i_in_data.pulse_ticks;
        end
        if (r_state == S_CMP_MIN) begin
            r_ge_min <= !w_borrow;
        end
        if (r_state == S_CMP_MAX) begin
            r_le_max <= !w_borrow;
        end
        if (r_state == S_CMP_SYNC && w_chan_pulse && r_seen < CNT_MAX) begin
            r_store[r_seen[IDX_W-1:0]] <= r_len;
        end
        if (r_state == S_CH_HI) begin
            r_lo_byte <= w_diff[7:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min     <= RST_PULSE_MIN;
            r_pulse_max     <= RST_PULSE_MAX;
            r_sync_min      <= RST_SYNC_MIN;
            r_frames_needed <= RST_FRAMES_NEEDED;
            r_fs_throttle   <= RST_FS_THROTTLE;
            r_fs_neutral    <= RST_FS_NEUTRAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PULSE_MIN:     r_pulse_min     <= i_cfg_data;
                CFG_PULSE_MAX:     r_pulse_max     <= i_cfg_data;
                CFG_SYNC_MIN:      r_sync_min      <= i_cfg_data;
                CFG_FRAMES_NEEDED: r_frames_needed <= i_cfg_data[7:0];
                CFG_FS_THROTTLE:   r_fs_throttle   <= i_cfg_data;
                CFG_FS_NEUTRAL:    r_fs_neutral    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Output register: the byte waits here while the sequencer moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== src/ppmd_checker.sv =====
// ----------------------------------------------------------------------------
// ppmd_checker
// Port level checks of the pulse train decoder, bound to its top level.
// ----------------------------------------------------------------------------
module ppmd_checker
    import ppmd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A stalled output beat holds its place and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    // A captured pulse always occupies the compare sequence.
    a_pulse_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.req_type == REQ_PULSE)
        |=> !o_in_ready)
        else $error("input ready right after a pulse beat");

    // Failsafe frames go out only in failsafe mode, live frames never in it.
    a_fs_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.from_failsafe == (o_out_data.link_state == MODE_FS)))
        else $error("frame source disagrees with link state");

    // Within one frame the source flag and link state do not change.
    a_frame_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_byte ##1 o_out_valid
        |-> $stable(o_out_data.from_failsafe) && $stable(o_out_data.link_state))
        else $error("frame flags changed in mid frame");

endmodule

bind ppm_decode_to_serial_frame_top ppmd_checker u_ppmd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
